// File: sv/cbpc_pkg.sv
// cbpc_pkg: shared types, constants and helper functions for the
// configuration bitstream packet checker; no dependencies
package cbpc_pkg;

    localparam logic [31:0] SYNC_WORD   = 32'hAA99_5566;
    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam int          REG_W       = 14;
    localparam int          COUNT_W     = 27;
    localparam int          COUNT1_W    = 11;
    localparam logic [2:0]  TYPE_ONE    = 3'd1;
    localparam logic [2:0]  TYPE_TWO    = 3'd2;
    localparam logic [1:0]  OP_NOP      = 2'd0;
    localparam logic [1:0]  OP_WRITE    = 2'd2;
    localparam logic [REG_W-1:0] REG_CRC = 14'd0;
    localparam logic [REG_W-1:0] REG_FDRI = 14'd2;
    localparam logic [REG_W-1:0] REG_CMD  = 14'd4;
    localparam logic [31:0] CMD_RCRC    = 32'd7;

    // result kind codes
    typedef enum logic [3:0] {
        KIND_PRESYNC = 4'd0,
        KIND_SYNC    = 4'd1,
        KIND_HEADER  = 4'd2,
        KIND_DATA    = 4'd3,
        KIND_AUTOCRC = 4'd4,
        KIND_BADTYPE = 4'd5,
        KIND_BADOP   = 4'd6,
        KIND_T2ERR   = 4'd7,
        KIND_HALTED  = 4'd8
    } cbpc_kind_t;

    // parser state carried between words
    typedef struct packed {
        logic               synced;
        logic               halted;
        logic [15:0]        crc;
        logic [REG_W-1:0]   cur_reg;
        logic [COUNT_W-1:0] last_count;
        logic [COUNT_W-1:0] words_left;
        logic               autocrc_pending;
    } cbpc_state_t;

    // one result item
    typedef struct packed {
        cbpc_kind_t         kind;
        logic [31:0]        word_value;
        logic [15:0]        crc_value;
        logic               crc_is_zero;
        logic               packet_end;
        logic [REG_W-1:0]   reg_address;
        logic [COUNT_W-1:0] word_count;
        logic [3:0]         command_code;
    } cbpc_result_t;

    localparam cbpc_state_t STATE_RESET = '{
        synced: 1'b0, halted: 1'b0, crc: CRC_INIT, cur_reg: '0,
        last_count: '0, words_left: '0, autocrc_pending: 1'b0
    };

    // reverse the bit order inside each byte, byte positions kept
    function automatic logic [31:0] flip_bytes(input logic [31:0] w);
        logic [31:0] o;
        o = '0;
        for (int b = 0; b < 4; b++) begin
            for (int i = 0; i < 8; i++) begin
                o[8*b + 7 - i] = w[8*b + i];
            end
        end
        return o;
    endfunction

    // shift nbits of data, lsb first, into the crc
    function automatic logic [15:0] crc_shift(input logic [15:0] crc,
                                              input logic [31:0] data,
                                              input int          nbits);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 32; i++) begin
            if (i < nbits) begin
                fb = c[15] ^ data[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
        end
        return c;
    endfunction

endpackage

// File: sv/config_bitstream_packet_checker_core.sv
// config_bitstream_packet_checker_core: an accepted input transaction goes
// through the input register, the per-word parse and crc logic and the
// result register to its result on the master side; throughput one word
// per cycle unless m_tready stalls; 37 crc bit steps unrolled per word
// reset (aresetn low, synchronous) empties both registers and returns the
// parser to hunting for sync with the crc at 0xffff
module config_bitstream_packet_checker_core import cbpc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // slave side: raw configuration words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // raw_word[31:0]
    input  logic         s_tlast,   // end_of_stream
    // master side: one result per word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // word_value[31:0], crc_value[47:32],
                                    // crc_is_zero[48], reg_address[62:49],
                                    // word_count[89:63], command_code[93:90],
                                    // zero fill[95:94]
    output logic [3:0]   m_tuser,   // kind[3:0]
    output logic         m_tlast    // packet_end
);

    // input register
    logic         in_valid_reg;
    logic [31:0]  in_word_reg;
    logic         in_eos_reg;

    // parser state and result register
    cbpc_state_t  state_reg;
    cbpc_state_t  state_next;
    cbpc_result_t res_next;
    cbpc_result_t res_reg;
    logic         out_valid_reg;

    logic         out_free;
    logic         advance;

    // result register can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    cbpc_parser u_parser (
        .cur           (state_reg),
        .raw_word      (in_word_reg),
        .end_of_stream (in_eos_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    // state moves only when a word passes into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.packet_end;
    assign m_tdata  = {2'b00, res_reg.command_code, res_reg.word_count,
                       res_reg.reg_address, res_reg.crc_is_zero,
                       res_reg.crc_value, res_reg.word_value};

endmodule

// File: sv/cbpc_parser.sv
// cbpc_parser: per-word next-state and result logic of the packet checker
// depends on cbpc_pkg
module cbpc_parser import cbpc_pkg::*; (
    input  cbpc_state_t  cur,
    input  logic [31:0]  raw_word,
    input  logic         end_of_stream,
    output cbpc_state_t  nxt,
    output cbpc_result_t res
);

    logic [31:0]        v;
    logic [2:0]         ptype;
    logic [1:0]         op;
    cbpc_kind_t         kind;
    logic               pend;
    logic [3:0]         cmd;
    cbpc_state_t        st;
    logic [COUNT_W-1:0] wl_dec;

    assign v      = flip_bytes(raw_word);
    assign ptype  = v[31:29];
    assign op     = v[28:27];
    assign wl_dec = cur.words_left - COUNT_W'(1);

    always_comb begin
        st   = cur;
        kind = KIND_HEADER;
        pend = 1'b0;
        cmd  = 4'd0;
        if (cur.halted) begin
            kind = KIND_HALTED;
        end else if (!cur.synced) begin
            if (v == SYNC_WORD) begin
                st.synced = 1'b1;
                kind      = KIND_SYNC;
            end else begin
                kind = KIND_PRESYNC;
            end
        end else if (cur.autocrc_pending) begin
            st.crc             = crc_shift(cur.crc, {16'd0, v[15:0]}, 16);
            st.autocrc_pending = 1'b0;
            kind               = KIND_AUTOCRC;
            pend               = 1'b1;
        end else if (cur.words_left != '0) begin
            st.crc = crc_shift(crc_shift(cur.crc, v, 32),
                               {27'd0, cur.cur_reg[4:0]}, 5);
            if (cur.cur_reg == REG_CMD) begin
                cmd = v[3:0];
                if (v == CMD_RCRC) begin
                    st.crc = 16'd0;
                end
            end
            st.words_left = wl_dec;
            kind          = KIND_DATA;
            if (wl_dec == '0) begin
                if (cur.cur_reg == REG_FDRI && cur.last_count != '0) begin
                    st.autocrc_pending = 1'b1;
                end else begin
                    pend = 1'b1;
                end
            end
        end else begin
            if (ptype == TYPE_ONE) begin
                st.last_count = COUNT_W'(v[COUNT1_W-1:0]);
                st.cur_reg    = v[26:13];
            end else if (ptype == TYPE_TWO) begin
                if (cur.last_count != '0) begin
                    kind      = KIND_T2ERR;
                    st.halted = 1'b1;
                end else begin
                    st.last_count = v[COUNT_W-1:0];
                end
            end else begin
                kind      = KIND_BADTYPE;
                st.halted = 1'b1;
            end
            if (kind == KIND_HEADER && op != OP_NOP && op != OP_WRITE) begin
                kind      = KIND_BADOP;
                st.halted = 1'b1;
            end
            if (kind == KIND_HEADER) begin
                st.words_left = st.last_count;
                pend          = (st.last_count == '0);
            end
        end
    end

    assign res.kind         = kind;
    assign res.word_value   = v;
    assign res.crc_value    = st.crc;
    assign res.crc_is_zero  = (st.crc == 16'd0);
    assign res.packet_end   = pend;
    assign res.reg_address  = st.cur_reg;
    assign res.word_count   = st.last_count;
    assign res.command_code = cmd;

    // end of stream: result as usual, then back to hunting for sync
    assign nxt = end_of_stream ? STATE_RESET : st;

endmodule

// File: sv/cbpc_checker.sv
// cbpc_checker: port-level assertions for the packet checker core
// depends on cbpc_pkg; bound to config_bitstream_packet_checker_core below
module cbpc_checker import cbpc_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [3:0]   m_tuser,
    input logic         m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // zero flag agrees with the crc field
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[48] == (m_tdata[47:32] == 16'd0))
        else $error("crc zero flag mismatch");

    // command code only on data words
    a_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[93:90] != 4'd0 |-> m_tuser == KIND_DATA)
        else $error("command code outside a data word");

    // auto-crc word always closes its packet
    a_auto: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_AUTOCRC |-> m_tlast)
        else $error("auto-crc word without packet end");

    // no packet end while hunting for sync or halted
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_PRESYNC || m_tuser == KIND_HALTED
                     || m_tuser == KIND_SYNC) |-> !m_tlast)
        else $error("packet end outside a packet");

endmodule

bind config_bitstream_packet_checker_core cbpc_checker u_cbpc_checker (.*);

// File: dv/tb_config_bitstream_packet_checker_core.sv
// tb_config_bitstream_packet_checker_core: self-checking testbench for the
// configuration bitstream packet checker, with its own parse and crc tracker
// depends on cbpc_pkg and config_bitstream_packet_checker_core
module tb_config_bitstream_packet_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cbpc_pkg::*;

    // header codes that the block must reject
    localparam logic [2:0] TYPE_BAD_ZERO = 3'd0;
    localparam logic [1:0] OP_BAD_ONE    = 2'd1;
    localparam logic [1:0] OP_BAD_THREE  = 2'd3;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES = 4;     // margin after the last result has come back
    localparam int PHASE_WORDS  = 250;   // random words per idling phase

    // tracks the parser state word by word and holds the results still due
    class packet_parse_tracker;
        logic               synced;
        logic               halted;
        logic               autocrc_due;
        logic [15:0]        crc;
        logic [REG_W-1:0]   cur_reg;
        logic [COUNT_W-1:0] last_count;
        logic [COUNT_W-1:0] words_left;
        cbpc_result_t       results_due[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear();
        endfunction

        function void clear();
            synced      = 1'b0;
            halted      = 1'b0;
            autocrc_due = 1'b0;
            crc         = CRC_INIT;
            cur_reg     = '0;
            last_count  = '0;
            words_left  = '0;
        endfunction

        // mirror bit order within each byte; its own inverse
        static function logic [31:0] mirror_bytes(logic [31:0] w);
            logic [31:0] o;
            for (int i = 0; i < 32; i++) begin
                o[(i & ~7) + 7 - (i & 7)] = w[i];
            end
            return o;
        endfunction

        // lsb-first feed of n bits into the crc-16
        static function logic [15:0] crc16_feed(logic [15:0] c, logic [31:0] d, int n);
            logic fb;
            for (int i = 0; i < n; i++) begin
                fb = c[15] ^ d[i];
                c  = c << 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction

        // one accepted input transaction: advance the parser, queue its result
        function void note_word(logic [31:0] raw, logic eos);
            logic [31:0]  v;
            logic [2:0]   ptype;
            logic [1:0]   popc;
            cbpc_result_t r;
            v            = mirror_bytes(raw);
            r            = '0;
            r.word_value = v;
            if (halted) begin
                r.kind = KIND_HALTED;
            end else if (!synced) begin
                if (v == SYNC_WORD) begin
                    synced = 1'b1;
                    r.kind = KIND_SYNC;
                end else begin
                    r.kind = KIND_PRESYNC;
                end
            end else if (autocrc_due) begin
                crc          = crc16_feed(crc, {16'h0, v[15:0]}, 16);
                autocrc_due  = 1'b0;
                r.kind       = KIND_AUTOCRC;
                r.packet_end = 1'b1;
            end else if (words_left != 0) begin
                crc = crc16_feed(crc, v, 32);
                crc = crc16_feed(crc, {27'h0, cur_reg[4:0]}, 5);
                if (cur_reg == REG_CMD) begin
                    r.command_code = v[3:0];
                    if (v == CMD_RCRC) begin
                        crc = '0;
                    end
                end
                words_left = words_left - 1'b1;
                r.kind     = KIND_DATA;
                if (words_left == 0) begin
                    if (cur_reg == REG_FDRI && last_count != 0) begin
                        autocrc_due = 1'b1;
                    end else begin
                        r.packet_end = 1'b1;
                    end
                end
            end else begin
                ptype  = v[31:29];
                popc   = v[28:27];
                r.kind = KIND_HEADER;
                if (ptype == TYPE_ONE) begin
                    last_count = {16'h0, v[10:0]};
                    cur_reg    = v[26:13];
                end else if (ptype == TYPE_TWO) begin
                    if (last_count != 0) begin
                        r.kind = KIND_T2ERR;
                        halted = 1'b1;
                    end else begin
                        last_count = v[26:0];
                    end
                end else begin
                    r.kind = KIND_BADTYPE;
                    halted = 1'b1;
                end
                if (r.kind == KIND_HEADER && popc != OP_NOP && popc != OP_WRITE) begin
                    r.kind = KIND_BADOP;
                    halted = 1'b1;
                end
                if (r.kind == KIND_HEADER) begin
                    words_left   = last_count;
                    r.packet_end = (last_count == 0);
                end
            end
            r.crc_value   = crc;
            r.crc_is_zero = (crc == 0);
            r.reg_address = cur_reg;
            r.word_count  = last_count;
            results_due.push_back(r);
            if (eos) begin
                clear();
            end
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 100) begin
                $display("result %0d: %s is 0x%0h, expected 0x%0h",
                         results_seen, field, got, want);
            end
        endtask

        // one accepted result transaction, against the oldest one due
        task check_result(cbpc_result_t got);
            cbpc_result_t want;
            results_seen++;
            if (results_due.size() == 0) begin
                report("unexpected result, word_value", got.word_value, '0);
                return;
            end
            want = results_due.pop_front();
            if (got.kind !== want.kind) report("kind", got.kind, want.kind);
            if (got.word_value !== want.word_value)
                report("word_value", got.word_value, want.word_value);
            if (got.crc_value !== want.crc_value)
                report("crc_value", got.crc_value, want.crc_value);
            if (got.crc_is_zero !== want.crc_is_zero)
                report("crc_is_zero", got.crc_is_zero, want.crc_is_zero);
            if (got.packet_end !== want.packet_end)
                report("packet_end", got.packet_end, want.packet_end);
            if (got.reg_address !== want.reg_address)
                report("reg_address", got.reg_address, want.reg_address);
            if (got.word_count !== want.word_count)
                report("word_count", got.word_count, want.word_count);
            if (got.command_code !== want.command_code)
                report("command_code", got.command_code, want.command_code);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    packet_parse_tracker tracker;

    int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int recv_idle_pct = 0;   // same for the receiver
    int hold_requests = 0;   // bumped by the main sequence to ask for a long hold-off
    int hold_served   = 0;
    int hold_left     = 0;
    int words_sent    = 0;

    config_bitstream_packet_checker_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // receiver: random stalls, plus a counted hold-off whenever one is asked for
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // both handshakes sampled at the edge; the result side goes first, though a
    // word accepted now cannot have its result out at the same edge anyway
    always @(posedge aclk) begin : bus_monitor
        cbpc_result_t seen;
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready) begin
                seen.kind         = cbpc_kind_t'(m_tuser);
                seen.word_value   = m_tdata[31:0];
                seen.crc_value    = m_tdata[47:32];
                seen.crc_is_zero  = m_tdata[48];
                seen.reg_address  = m_tdata[62:49];
                seen.word_count   = m_tdata[89:63];
                seen.command_code = m_tdata[93:90];
                seen.packet_end   = m_tlast;
                tracker.check_result(seen);
            end
            if (s_tvalid && s_tready === 1'b1) begin
                tracker.note_word(s_tdata, s_tlast);
            end
        end
    end

    // watchdog: too long without any transaction on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("config_bitstream_packet_checker_core verification failed");
        $finish;
    end

    // headers built in decoded bit order; the spare bits 12..11 carry noise
    function automatic logic [31:0] type1_header(logic [1:0] op, logic [13:0] target,
                                                 logic [10:0] count);
        return {TYPE_ONE, op, target, 2'($urandom), count};
    endfunction

    function automatic logic [31:0] type2_header(logic [1:0] op, logic [26:0] count);
        return {TYPE_TWO, op, count};
    endfunction

    // payload: command writes favour the crc reset command and small codes
    function automatic logic [31:0] data_word(logic [13:0] target);
        int pick;
        pick = $urandom_range(9);
        if (target != REG_CMD || pick > 6) begin
            return $urandom;
        end
        if (pick < 3) begin
            return CMD_RCRC;
        end
        return $urandom_range(15);
    endfunction

    // offer one word (given in decoded order) and wait for its transaction;
    // valid is left high so that a following word goes out back to back
    task automatic send_word(logic [31:0] word, logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packet_parse_tracker::mirror_bytes(word);
        s_tlast  <= eos;
        @(posedge aclk);
        while (s_tready !== 1'b1) begin
            @(posedge aclk);
        end
        words_sent++;
    endtask

    // sender pause until every result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one stream: a little noise, sync, a run of mostly well-formed packets, then
    // end of stream; a few streams carry a broken header and end soon after
    task automatic send_random_stream();
        int          n_noise;
        int          n_pkts;
        int          n_data;
        int          k;
        logic [13:0] target;
        logic [1:0]  op;
        logic [26:0] count;
        logic [2:0]  ptype;
        logic        two_part;
        n_noise = $urandom_range(3);
        repeat (n_noise) send_word($urandom, 1'b0);
        send_word(SYNC_WORD, 1'b0);
        n_pkts = $urandom_range(1, 8);
        repeat (n_pkts) begin
            if ($urandom_range(99) < 6) begin
                case ($urandom_range(3))
                    0: begin
                        do ptype = 3'($urandom); while (ptype == TYPE_ONE || ptype == TYPE_TWO);
                        send_word({ptype, 29'($urandom)}, 1'b0);
                    end
                    1: begin
                        op = $urandom_range(1) ? OP_BAD_THREE : OP_BAD_ONE;
                        send_word(type1_header(op, 14'($urandom), 11'($urandom)), 1'b0);
                    end
                    2: begin
                        // type-2 header while the last count is still nonzero
                        send_word(type1_header(OP_WRITE, REG_CRC, 11'd1), 1'b0);
                        send_word($urandom, 1'b0);
                        send_word(type2_header(OP_WRITE, 27'($urandom)), 1'b0);
                    end
                    default: send_word($urandom, 1'b0);
                endcase
                n_data = $urandom_range(2);
                repeat (n_data) send_word($urandom, 1'b0);
                send_word($urandom, 1'b1);
                return;
            end
            case ($urandom_range(7))
                0, 1, 2: target = REG_FDRI;
                3, 4:    target = REG_CMD;
                5:       target = REG_CRC;
                default: target = 14'($urandom);
            endcase
            op       = ($urandom_range(4) == 0) ? OP_NOP : OP_WRITE;
            two_part = ($urandom_range(9) < 3);
            k        = $urandom_range(99);
            if (k < 12) begin
                count = '0;
            end else if (k < 80) begin
                count = 27'($urandom_range(1, 4));
            end else if (k < 97) begin
                count = 27'($urandom_range(5, 24));
            end else if (two_part) begin
                count = 27'($urandom_range(41, 27'h7ff_ffff));
            end else begin
                count = 27'($urandom_range(41, 11'h7ff));
            end
            if (two_part) begin
                send_word(type1_header(op, target, '0), 1'b0);
                send_word(type2_header(op, count), 1'b0);
            end else begin
                send_word(type1_header(op, target, count[10:0]), 1'b0);
            end
            // long packets are cut short by end of stream
            n_data = (count > 40) ? $urandom_range(1, 3) : int'(count);
            for (int i = 0; i < n_data; i++) begin
                if ((count > 40 && i == n_data - 1) || $urandom_range(99) < 2) begin
                    send_word(data_word(target), 1'b1);
                    return;
                end
                send_word(data_word(target), 1'b0);
            end
            if (target == REG_FDRI && count != 0) begin
                send_word($urandom, 1'b0);   // auto-crc word
            end
        end
        // closing empty nop header carries end of stream
        send_word(type1_header(OP_NOP, 14'($urandom), '0), 1'b1);
    endtask

    initial begin : main_sequence
        int phase_end;
        tracker  = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // phase one: sender idles lightly, receiver heavily
        send_idle_pct = 22;
        recv_idle_pct = 51;

        // directed words
        send_word(32'h0000_0000, 1'b1);                        // end of stream before sync
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_WRITE, REG_CMD, 11'd1), 1'b0);
        send_word(CMD_RCRC, 1'b0);                             // crc cleared to zero
        send_word(type1_header(OP_NOP, REG_CRC, 11'd0), 1'b0); // empty packet ends on header
        send_word(type1_header(OP_WRITE, REG_FDRI, 11'd0), 1'b0);
        send_word(type2_header(OP_WRITE, 27'd2), 1'b0);        // type-2 keeps the register
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h1234_ABCD, 1'b0);                        // auto-crc word
        send_word(type1_header(OP_WRITE, 14'h3fff, 11'h7ff), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);                        // end of stream mid packet
        send_word(SYNC_WORD, 1'b0);
        send_word(type2_header(OP_WRITE, 27'h7ff_ffff), 1'b0); // largest type-2 count
        send_word(32'hA5A5_5A5A, 1'b1);
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_WRITE, REG_FDRI, 11'd1), 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'hFFFF_0000, 1'b0);                        // auto-crc word
        send_word(type2_header(OP_WRITE, 27'd5), 1'b0);        // type-2 after nonzero count
        send_word(32'hFFFF_FFFF, 1'b1);                        // halted word, end of stream
        send_word(SYNC_WORD, 1'b0);
        send_word({TYPE_BAD_ZERO, OP_WRITE, 27'd3}, 1'b1);     // bad packet type
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_BAD_THREE, 14'h1555, 11'h2aa), 1'b1); // bad opcode

        phase_end = words_sent + PHASE_WORDS;
        while (words_sent < phase_end) send_random_stream();
        wait_for_results();

        // phase two: the other way round
        send_idle_pct = 51;
        recv_idle_pct = 22;
        phase_end     = words_sent + PHASE_WORDS;
        while (words_sent < phase_end) send_random_stream();
        wait_for_results();

        // phase three: no idling, with one long receiver hold-off that backs the
        // block up against the sender
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        phase_end = words_sent + PHASE_WORDS;
        while (words_sent < phase_end) send_random_stream();
        wait_for_results();

        if (tracker.mismatches == 0) begin
            $display("config_bitstream_packet_checker_core verification clean");
        end else begin
            $display("config_bitstream_packet_checker_core verification failed");
        end
        $finish;
    end

endmodule
